FILE: rtl/fnps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnps_pkg
// Shared widths, defaults, register indexes and controller/datapath structs
// for the four-neighbour positive sum block.
// ----------------------------------------------------------------------------
package fnps_pkg;

    localparam int MAX_COLS_DEF    = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int ELEM_W      = 16;
    localparam int SUM_OUT_W   = 17;
    localparam int ROW_W       = 16;
    localparam int COL_OUT_W   = 5;
    localparam int COL_CFG_W   = 6;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 4'd1;

    typedef struct packed {
        logic accept;      // store the input word, capture item context
        logic load_norm;   // set up the cell of the row above
        logic load_flush;  // set up column 0 of the last row
        logic next_flush;  // step to the next column of the last row
        logic issue;       // read one neighbour
        logic emit;        // move the sum into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic it_row_nz;   // item is not in row 0
        logic it_final;    // item is the last element of the matrix
        logic k_last;      // last neighbour being read
        logic flush_mode;
        logic flush_last;  // current flush cell is the last column
        logic out_free;    // output register can take a word
    } t_dp_status;

endpackage

FILE: rtl/fnps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnps_ctrl
// Sequencer: accepts one word, then walks each result through four
// neighbour reads, the drain state and the output hand-off.
// ----------------------------------------------------------------------------
module fnps_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  fnps_pkg::t_dp_status i_status,
    output fnps_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SEL   = 5'b00010,
        S_RUN   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_SEL;
                end
            end
            S_SEL: begin
                if (i_status.it_row_nz) begin
                    o_cmd.load_norm = 1'b1;
                    n_state         = S_RUN;
                end else if (i_status.it_final) begin
                    o_cmd.load_flush = 1'b1;
                    n_state          = S_RUN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (i_status.k_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.flush_mode) begin
                        if (i_status.flush_last) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.next_flush = 1'b1;
                            n_state          = S_RUN;
                        end
                    end else if (i_status.it_final) begin
                        o_cmd.load_flush = 1'b1;
                        n_state          = S_RUN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_drain_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> $past(r_state == S_RUN))
        else $error("drain not preceded by neighbour reads");
`endif

endmodule

FILE: rtl/fnps_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnps_datapath
// Row ring memory, matrix counters, neighbour address select, accumulator
// and output register.
// ----------------------------------------------------------------------------
module fnps_datapath #(
    parameter int MAX_COLS    = fnps_pkg::MAX_COLS_DEF,
    parameter int SAMPLE_BITS = fnps_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fnps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fnps_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic signed [fnps_pkg::ELEM_W-1:0]  i_element_value,
    input  fnps_pkg::t_dp_cmd                   i_cmd,
    output fnps_pkg::t_dp_status                o_status,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [fnps_pkg::SUM_OUT_W-1:0]      o_neighbour_sum,
    output logic [fnps_pkg::ROW_W-1:0]          o_cell_row,
    output logic [fnps_pkg::COL_OUT_W-1:0]      o_cell_col,
    output logic                                o_last_of_matrix
);

    localparam int CW    = $clog2(MAX_COLS);
    localparam int CNTW  = $clog2(MAX_COLS + 1);
    localparam int DEPTH = 3 * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SUMW  = SAMPLE_BITS + 2;
    localparam int SWIDE = (SUMW > fnps_pkg::SUM_OUT_W) ? SUMW : fnps_pkg::SUM_OUT_W;
    localparam int CWIDE = (CW > fnps_pkg::COL_OUT_W) ? CW : fnps_pkg::COL_OUT_W;
    localparam int RW    = fnps_pkg::ROW_W;

    typedef enum logic [1:0] {
        NBR_UP    = 2'd0,
        NBR_DOWN  = 2'd1,
        NBR_LEFT  = 2'd2,
        NBR_RIGHT = 2'd3
    } t_nbr;

    function automatic logic [1:0] slot_after(input logic [1:0] s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

    function automatic logic [1:0] slot_before(input logic [1:0] s);
        return (s == 2'd0) ? 2'd2 : s - 2'd1;
    endfunction

    function automatic logic [AW-1:0] mem_addr(input logic [1:0] s, input logic [CW-1:0] c);
        return AW'(s) * AW'(MAX_COLS) + AW'(c);
    endfunction

    logic [SAMPLE_BITS-1:0] mem [DEPTH];

    // configuration and matrix position
    logic [RW-1:0]                  r_row_cfg;
    logic [fnps_pkg::COL_CFG_W-1:0] r_col_cfg;
    logic [RW-1:0]                  r_cur_row;
    logic [CW-1:0]                  r_cur_col;
    logic [1:0]                     r_phase;

    // captured item
    logic [RW-1:0] r_it_row;
    logic [CW-1:0] r_it_col;
    logic [1:0]    r_it_cur;
    logic          r_it_final;

    // cell being summed
    logic [RW-1:0] r_t_row;
    logic [CW-1:0] r_t_col;
    logic [1:0]    r_mid_slot;
    logic [1:0]    r_up_slot;
    logic [1:0]    r_down_slot;
    logic          r_has_up;
    logic          r_has_down;
    logic          r_flush;
    t_nbr          r_k;

    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic                   r_pres;
    logic [SUMW-1:0]        r_acc;

    logic                          r_out_valid;
    logic [fnps_pkg::SUM_OUT_W-1:0] r_out_sum;
    logic [RW-1:0]                 r_out_row;
    logic [fnps_pkg::COL_OUT_W-1:0] r_out_col;
    logic                          r_out_last;

    logic [RW-1:0]          rows_eff;
    logic [CNTW-1:0]        cols_eff;
    logic                   restart;
    logic [RW-1:0]          eff_row;
    logic [CW-1:0]          eff_col;
    logic [1:0]             eff_cur;
    logic                   item_final;
    logic [CNTW-1:0]        col_inc;
    logic [AW-1:0]          wr_addr;
    logic [SAMPLE_BITS-1:0] sample;
    logic [fnps_pkg::ELEM_W-1:0] raw_elem;
    logic [1:0]             nb_slot;
    logic [CW-1:0]          nb_col;
    logic                   nb_pres;
    logic [SUMW-1:0]        pos_part;
    logic [SWIDE-1:0]       sum_wide;
    logic [CWIDE-1:0]       col_wide;
    logic                   out_free;
    logic                   cfg_hit;

    assign rows_eff = (r_row_cfg == '0) ? RW'(1) : r_row_cfg;

    always_comb begin
        if (r_col_cfg == '0) begin
            cols_eff = CNTW'(1);
        end else if (32'(r_col_cfg) > MAX_COLS) begin
            cols_eff = CNTW'(MAX_COLS);
        end else begin
            cols_eff = CNTW'(r_col_cfg);
        end
    end

    // stale position after a config change acts as a fresh matrix
    assign restart = (r_cur_row >= rows_eff) || (CNTW'(r_cur_col) >= cols_eff)
                   || (r_phase > 2'd2);
    assign eff_row = restart ? '0 : r_cur_row;
    assign eff_col = restart ? '0 : r_cur_col;
    assign eff_cur = restart ? '0 : r_phase;

    assign item_final = (eff_row == rows_eff - RW'(1))
                      && (CNTW'(eff_col) == cols_eff - CNTW'(1));
    assign col_inc    = CNTW'(eff_col) + CNTW'(1);
    assign wr_addr    = mem_addr(eff_cur, eff_col);
    assign raw_elem   = i_element_value;
    assign sample     = SAMPLE_BITS'(raw_elem);
    assign cfg_hit    = i_cfg_we && ((i_cfg_index == fnps_pkg::REG_ROW_COUNT)
                                  || (i_cfg_index == fnps_pkg::REG_COL_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cfg <= RW'(1);
            r_col_cfg <= fnps_pkg::COL_CFG_W'(32);
            r_cur_row <= '0;
            r_cur_col <= '0;
            r_phase   <= '0;
        end else begin
            if (i_cmd.accept) begin
                if (item_final) begin
                    r_cur_row <= '0;
                    r_cur_col <= '0;
                    r_phase   <= '0;
                end else if (col_inc >= cols_eff) begin
                    r_cur_row <= eff_row + RW'(1);
                    r_cur_col <= '0;
                    r_phase   <= slot_after(eff_cur);
                end else begin
                    r_cur_row <= eff_row;
                    r_cur_col <= CW'(col_inc);
                    r_phase   <= eff_cur;
                end
            end
            if (i_cfg_we && (i_cfg_index == fnps_pkg::REG_ROW_COUNT)) begin
                r_row_cfg <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == fnps_pkg::REG_COL_COUNT)) begin
                r_col_cfg <= i_cfg_data[fnps_pkg::COL_CFG_W-1:0];
            end
            if (cfg_hit) begin
                r_cur_row <= '0;
                r_cur_col <= '0;
                r_phase   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            mem[wr_addr] <= sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_it_row   <= eff_row;
            r_it_col   <= eff_col;
            r_it_cur   <= eff_cur;
            r_it_final <= item_final;
        end
    end

    // neighbour select for the read in flight
    always_comb begin
        case (r_k)
            NBR_UP: begin
                nb_slot = r_up_slot;
                nb_col  = r_t_col;
                nb_pres = r_has_up;
            end
            NBR_DOWN: begin
                nb_slot = r_down_slot;
                nb_col  = r_t_col;
                nb_pres = r_has_down;
            end
            NBR_LEFT: begin
                nb_slot = r_mid_slot;
                nb_col  = r_t_col - CW'(1);
                nb_pres = (r_t_col != '0);
            end
            default: begin
                nb_slot = r_mid_slot;
                nb_col  = r_t_col + CW'(1);
                nb_pres = (CNTW'(r_t_col) + CNTW'(1)) < cols_eff;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_data <= mem[mem_addr(nb_slot, nb_col)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pres  <= 1'b0;
            r_flush <= 1'b0;
            r_k     <= NBR_UP;
        end else begin
            r_pres <= i_cmd.issue && nb_pres;
            if (i_cmd.issue) begin
                r_k <= t_nbr'(r_k + 2'd1);
            end
            if (i_cmd.load_norm) begin
                r_flush <= 1'b0;
                r_k     <= NBR_UP;
            end
            if (i_cmd.load_flush || i_cmd.next_flush) begin
                r_flush <= 1'b1;
                r_k     <= NBR_UP;
            end
        end
    end

    assign pos_part = r_rd_data[SAMPLE_BITS-1] ? '0 : SUMW'(r_rd_data);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_norm) begin
            r_t_row     <= r_it_row - RW'(1);
            r_t_col     <= r_it_col;
            r_mid_slot  <= slot_before(r_it_cur);
            r_up_slot   <= slot_after(r_it_cur);
            r_down_slot <= r_it_cur;
            r_has_up    <= (r_it_row >= RW'(2));
            r_has_down  <= 1'b1;
        end
        if (i_cmd.load_flush || i_cmd.next_flush) begin
            r_t_row     <= r_it_row;
            r_t_col     <= i_cmd.next_flush ? r_t_col + CW'(1) : '0;
            r_mid_slot  <= r_it_cur;
            r_up_slot   <= slot_before(r_it_cur);
            r_down_slot <= r_it_cur;
            r_has_up    <= (r_it_row != '0);
            r_has_down  <= 1'b0;
        end
        if (i_cmd.load_norm || i_cmd.load_flush || i_cmd.next_flush) begin
            r_acc <= '0;
        end else if (r_pres) begin
            r_acc <= r_acc + pos_part;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign sum_wide = SWIDE'(r_acc);
    assign col_wide = CWIDE'(r_t_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_sum  <= sum_wide[fnps_pkg::SUM_OUT_W-1:0];
            r_out_row  <= r_t_row;
            r_out_col  <= col_wide[fnps_pkg::COL_OUT_W-1:0];
            r_out_last <= o_status.flush_last;
        end
    end

    assign o_status.it_row_nz  = (r_it_row != '0);
    assign o_status.it_final   = r_it_final;
    assign o_status.k_last     = (r_k == NBR_RIGHT);
    assign o_status.flush_mode = r_flush;
    assign o_status.flush_last = r_flush && (CNTW'(r_t_col) == cols_eff - CNTW'(1));
    assign o_status.out_free   = out_free;

    assign o_out_valid      = r_out_valid;
    assign o_neighbour_sum  = r_out_sum;
    assign o_cell_row       = r_out_row;
    assign o_cell_col       = r_out_col;
    assign o_last_of_matrix = r_out_last;

`ifndef SYNTHESIS
    a_emit_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result emitted over an unread word");
    a_acc_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pres |-> $past(i_cmd.issue))
        else $error("accumulate without a neighbour read");
    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |-> (32'(wr_addr) < DEPTH))
        else $error("row store write address out of range");
`endif

endmodule

FILE: rtl/four_neighbour_positive_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_neighbour_positive_sum
// Streams a row-major matrix and returns, per cell, the sum of its
// non-negative up/down/left/right neighbours.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready) takes one element word at a time.
//   Output channel (o_out_valid/i_out_ready) gives sum, cell row/col and a
//   last-of-matrix flag. Config port writes row count (index 0) and column
//   count (index 1); either write restarts the matrix.
//   A word in row 0 (except the final one) produces nothing. A word in any
//   later row produces the sum of the cell above it.
//   The final word also sends out the whole last row.
//   Each result is four reads on the single row-store read port, a drain
//   step and an output hand-off.
//   The output register lets the next word be accepted while a result
//   waits; a stalled receiver holds the sequencer only when a new result
//   is ready to be written.
//   Reset clears the counters, handshake state and config (1 row,
//   32 columns); the row store needs no clearing.
// ----------------------------------------------------------------------------
module four_neighbour_positive_sum #(
    parameter int MAX_COLS    = fnps_pkg::MAX_COLS_DEF,
    parameter int SAMPLE_BITS = fnps_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fnps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fnps_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [fnps_pkg::ELEM_W-1:0]  i_element_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [fnps_pkg::SUM_OUT_W-1:0]      o_neighbour_sum,
    output logic [fnps_pkg::ROW_W-1:0]          o_cell_row,
    output logic [fnps_pkg::COL_OUT_W-1:0]      o_cell_col,
    output logic                                o_last_of_matrix
);

    fnps_pkg::t_dp_cmd    cmd;
    fnps_pkg::t_dp_status status;

    fnps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    fnps_datapath #(
        .MAX_COLS    (MAX_COLS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_element_value  (i_element_value),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_neighbour_sum  (o_neighbour_sum),
        .o_cell_row       (o_cell_row),
        .o_cell_col       (o_cell_col),
        .o_last_of_matrix (o_last_of_matrix)
    );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for four_neighbour_positive_sum. A directed script
// covers size extremes, single row/column matrices and register corner
// cases. Random matrices of assorted shapes follow. Every result word is
// compared against an in-bench model of the row ring under random stalls.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_COLS     = fnps_pkg::MAX_COLS_DEF;
    localparam int ELEM_W       = fnps_pkg::ELEM_W;
    localparam int SUM_OUT_W    = fnps_pkg::SUM_OUT_W;
    localparam int ROW_W        = fnps_pkg::ROW_W;
    localparam int COL_OUT_W    = fnps_pkg::COL_OUT_W;
    localparam int COL_CFG_W    = fnps_pkg::COL_CFG_W;
    localparam int CFG_DATA_W   = fnps_pkg::CFG_DATA_W;
    localparam int CFG_IDX_W    = fnps_pkg::CFG_IDX_W;
    localparam int RANDOM_WORDS = 410;
    localparam int DRAIN_CYCLES = 40;
    localparam int SCRIPT_LEN   = 32;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

    typedef enum logic {STEP_CFG, STEP_WORD} t_step_kind;

    typedef struct packed {
        logic [SUM_OUT_W-1:0] sum;
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] col;
        logic                 is_last;
    } t_cell_result;

    // data holds the register value or the element word
    typedef struct packed {
        t_step_kind           kind;
        logic [CFG_IDX_W-1:0] index;
        logic [15:0]          data;
        logic                 typed;
        t_cell_result         want;
    } t_script_step;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic signed [ELEM_W-1:0]   i_element_value = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [SUM_OUT_W-1:0]       o_neighbour_sum;
    logic [ROW_W-1:0]           o_cell_row;
    logic [COL_OUT_W-1:0]       o_cell_col;
    logic                       o_last_of_matrix;

    four_neighbour_positive_sum u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_element_value  (i_element_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_neighbour_sum  (o_neighbour_sum),
        .o_cell_row       (o_cell_row),
        .o_cell_col       (o_cell_col),
        .o_last_of_matrix (o_last_of_matrix)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #(50_000_000);
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Row ring model
    // ------------------------------------------------------------------------
    logic signed [ELEM_W-1:0] ring [3][MAX_COLS];
    int unsigned              at_row = 0;
    int unsigned              at_col = 0;
    int unsigned              at_slot = 0;
    logic [ROW_W-1:0]         rows_reg = 16'd1;
    logic [COL_CFG_W-1:0]     cols_reg = 6'd32;

    t_cell_result expected_sums [$];
    int unsigned  mismatches = 0;
    bit           steady = 1'b0;

    initial begin
        for (int s = 0; s < 3; s++)
            for (int c = 0; c < MAX_COLS; c++)
                ring[s][c] = '0;
    end

    function automatic int unsigned rows_eff();
        return (rows_reg == 0) ? 1 : int'(rows_reg);
    endfunction

    function automatic int unsigned cols_eff();
        if (cols_reg == 0)
            return 1;
        if (cols_reg > MAX_COLS)
            return MAX_COLS;
        return int'(cols_reg);
    endfunction

    function automatic logic [SUM_OUT_W-1:0] pos_part(logic signed [ELEM_W-1:0] v);
        return v[ELEM_W-1] ? '0 : SUM_OUT_W'(v);
    endfunction

    function automatic logic [SUM_OUT_W-1:0] neighbour_total(bit has_up, int unsigned up_slot,
            bit has_down, int unsigned down_slot, int unsigned mid_slot, int unsigned col,
            int unsigned ncols);
        logic [SUM_OUT_W-1:0] s;
        s = '0;
        if (has_up)
            s += pos_part(ring[up_slot][col]);
        if (has_down)
            s += pos_part(ring[down_slot][col]);
        if (col >= 1)
            s += pos_part(ring[mid_slot][col-1]);
        if (col + 1 < ncols)
            s += pos_part(ring[mid_slot][col+1]);
        return s;
    endfunction

    task automatic restart_matrix();
        at_row  = 0;
        at_col  = 0;
        at_slot = 0;
    endtask

    // store one word and queue the sums it completes
    task automatic predict_sums(input logic signed [ELEM_W-1:0] v);
        int unsigned  nr, nc, r, c, cur, prev, prev2;
        bit           last_word;
        t_cell_result res;
        nr = rows_eff();
        nc = cols_eff();
        if (at_row >= nr || at_col >= nc)
            restart_matrix();
        r     = at_row;
        c     = at_col;
        cur   = at_slot;
        prev  = (cur + 2) % 3;
        prev2 = (cur + 1) % 3;
        ring[cur][c] = v;
        last_word = (r == nr - 1) && (c == nc - 1);
        if (r >= 1) begin
            res.sum     = neighbour_total(r >= 2, prev2, 1'b1, cur, prev, c, nc);
            res.row     = ROW_W'(r - 1);
            res.col     = COL_OUT_W'(c);
            res.is_last = 1'b0;
            expected_sums.push_back(res);
        end
        if (last_word) begin
            // flush the whole last row
            for (int unsigned j = 0; j < nc; j++) begin
                res.sum     = neighbour_total(r >= 1, prev, 1'b0, cur, cur, j, nc);
                res.row     = ROW_W'(r);
                res.col     = COL_OUT_W'(j);
                res.is_last = (j == nc - 1);
                expected_sums.push_back(res);
            end
            restart_matrix();
        end else begin
            c++;
            if (c >= nc) begin
                c = 0;
                r++;
                at_slot = (cur + 1) % 3;
            end
            at_row = r;
            at_col = c;
        end
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_element(input logic signed [ELEM_W-1:0] v, input bit use_typed,
            input t_cell_result typed_res);
        int unsigned gap;
        int unsigned first;
        gap = steady ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_element_value <= v;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        first = expected_sums.size();
        predict_sums(v);
        if (use_typed && expected_sums.size() > first)
            expected_sums[first] = typed_res;
    endtask

    // hold the input until every queued sum has come out
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
            input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            fnps_pkg::REG_ROW_COUNT: begin
                rows_reg = data[ROW_W-1:0];
                restart_matrix();
            end
            fnps_pkg::REG_COL_COUNT: begin
                cols_reg = data[COL_CFG_W-1:0];
                restart_matrix();
            end
            default: ;
        endcase
    endtask

    function automatic logic signed [ELEM_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    initial begin : receiver
        int unsigned stall;
        forever begin
            stall = steady ? 0 : $urandom_range(0, 10);
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Result check
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want,
            input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_cell_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_sums.size() == 0) begin
                $display("%0t: unexpected word expected none actual sum %0d row %0d col %0d",
                         $time, o_neighbour_sum, o_cell_row, o_cell_col);
                mismatches++;
            end else begin
                want = expected_sums.pop_front();
                check_field("neighbour_sum", want.sum, o_neighbour_sum);
                check_field("cell_row", want.row, o_cell_row);
                check_field("cell_col", want.col, o_cell_col);
                check_field("last_of_matrix", want.is_last, o_last_of_matrix);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    t_script_step script_steps [SCRIPT_LEN] = '{
        // zero sizes act as 1x1
        '{STEP_CFG,  fnps_pkg::REG_ROW_COUNT, 16'h0000, 1'b0, '0},
        '{STEP_CFG,  fnps_pkg::REG_COL_COUNT, 16'h0000, 1'b0, '0},
        '{STEP_WORD, '0, 16'h8000, 1'b1, '{17'd0, 16'd0, 5'd0, 1'b1}},
        '{STEP_WORD, '0, 16'h7FFF, 1'b1, '{17'd0, 16'd0, 5'd0, 1'b1}},
        // upper data bits dropped: 3 columns, single row
        '{STEP_CFG,  fnps_pkg::REG_COL_COUNT, 16'h0043, 1'b0, '0},
        '{STEP_CFG,  fnps_pkg::REG_ROW_COUNT, 16'h0001, 1'b0, '0},
        '{STEP_WORD, '0, 16'h7FFF, 1'b0, '0},
        '{STEP_WORD, '0, 16'hFFFF, 1'b0, '0},
        '{STEP_WORD, '0, 16'h7FFF, 1'b0, '0},
        // single column
        '{STEP_CFG,  fnps_pkg::REG_ROW_COUNT, 16'h0003, 1'b0, '0},
        '{STEP_CFG,  fnps_pkg::REG_COL_COUNT, 16'h0001, 1'b0, '0},
        '{STEP_WORD, '0, 16'h0064, 1'b0, '0},
        '{STEP_WORD, '0, 16'h7FFF, 1'b1, '{17'd32767, 16'd0, 5'd0, 1'b0}},
        '{STEP_WORD, '0, 16'hFFFF, 1'b0, '0},
        // 3x3 with unused indexes written mid-matrix
        '{STEP_CFG,  fnps_pkg::REG_COL_COUNT, 16'h0003, 1'b0, '0},
        '{STEP_WORD, '0, 16'h7FFF, 1'b0, '0},
        '{STEP_WORD, '0, 16'h8000, 1'b0, '0},
        '{STEP_CFG,  REG_UNUSED_LO, 16'hFFFF, 1'b0, '0},
        '{STEP_CFG,  REG_UNUSED_HI, 16'hA5A5, 1'b0, '0},
        '{STEP_WORD, '0, 16'h0000, 1'b0, '0},
        '{STEP_WORD, '0, 16'hFFFF, 1'b1, '{17'd0, 16'd0, 5'd0, 1'b0}},
        '{STEP_WORD, '0, 16'h0001, 1'b0, '0},
        '{STEP_WORD, '0, 16'h7FFF, 1'b0, '0},
        '{STEP_WORD, '0, 16'h7FFF, 1'b0, '0},
        '{STEP_WORD, '0, 16'h7FFF, 1'b0, '0},
        '{STEP_WORD, '0, 16'h7FFF, 1'b0, '0},
        // 2x2
        '{STEP_CFG,  fnps_pkg::REG_ROW_COUNT, 16'h0002, 1'b0, '0},
        '{STEP_CFG,  fnps_pkg::REG_COL_COUNT, 16'h0002, 1'b0, '0},
        '{STEP_WORD, '0, 16'h0001, 1'b0, '0},
        '{STEP_WORD, '0, 16'h0002, 1'b0, '0},
        '{STEP_WORD, '0, 16'h0003, 1'b0, '0},
        '{STEP_WORD, '0, 16'h0004, 1'b0, '0}
    };

    initial begin : stimulus
        int unsigned          random_words;
        int unsigned          kind;
        int unsigned          n_mat;
        int unsigned          cells;
        int unsigned          n_words;
        bit                   big_done;
        logic [CFG_DATA_W-1:0] row_val;
        logic [CFG_DATA_W-1:0] col_val;

        random_words = 0;
        big_done     = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script_steps[i]) begin
            if (script_steps[i].kind == STEP_CFG) begin
                settle();
                write_register(script_steps[i].index, script_steps[i].data);
            end else begin
                send_element($signed(script_steps[i].data), script_steps[i].typed,
                             script_steps[i].want);
            end
        end

        while (random_words < RANDOM_WORDS) begin
            steady = ($urandom_range(0, 3) == 0);
            settle();
            kind  = big_done ? $urandom_range(0, 9) : 0;
            n_mat = 1;
            case (kind)
                0: begin
                    // tall matrix, often fed only partway
                    row_val  = big_done ? CFG_DATA_W'($urandom_range(7, 65535)) : 16'hFFFF;
                    col_val  = CFG_DATA_W'($urandom_range(1, 6));
                    big_done = 1'b1;
                end
                1: begin
                    row_val = CFG_DATA_W'($urandom_range(0, 3));
                    case ($urandom_range(0, 3))
                        0: col_val = CFG_DATA_W'(MAX_COLS);
                        1: col_val = CFG_DATA_W'($urandom_range(33, 63));
                        2: col_val = CFG_DATA_W'($urandom_range(1, 8))
                                     | CFG_DATA_W'($urandom_range(1, 1023) << 6);
                        default: col_val = '0;
                    endcase
                end
                default: begin
                    row_val = CFG_DATA_W'($urandom_range(0, 6));
                    col_val = CFG_DATA_W'($urandom_range(1, 8));
                    if ($urandom_range(0, 4) == 0)
                        col_val = col_val | CFG_DATA_W'($urandom_range(1, 1023) << 6);
                    n_mat = $urandom_range(1, 3);
                end
            endcase
            if ($urandom_range(0, 1)) begin
                write_register(fnps_pkg::REG_ROW_COUNT, row_val);
                write_register(fnps_pkg::REG_COL_COUNT, col_val);
            end else begin
                write_register(fnps_pkg::REG_COL_COUNT, col_val);
                write_register(fnps_pkg::REG_ROW_COUNT, row_val);
            end
            if ($urandom_range(0, 4) == 0)
                write_register(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                               CFG_DATA_W'($urandom));

            cells = rows_eff() * cols_eff();
            if (kind == 0) begin
                n_words = $urandom_range(10, 40);
            end else begin
                n_words = n_mat * cells;
                if (cells > 1 && $urandom_range(0, 4) == 0)
                    n_words -= $urandom_range(1, cells - 1);
            end
            for (int unsigned k = 0; k < n_words && random_words < RANDOM_WORDS; k++) begin
                if ($urandom_range(0, 39) == 0)
                    settle();
                send_element(random_word(), 1'b0, '0);
                random_words++;
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_sums.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: four_neighbour_positive_sum.f
rtl/fnps_pkg.sv
rtl/fnps_ctrl.sv
rtl/fnps_datapath.sv
rtl/four_neighbour_positive_sum.sv
verif/tb_top.sv
